@@ hdl/shsort_pkg.sv @@
// Shared types and constants for the shell_sorter block.
// No dependencies; imported by shell_sorter.
package shsort_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = ADDR_W + 1;   // holds 0..MAX_ITEMS
  localparam int unsigned J_W       = CNT_W + 1;    // signed scan index

  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_GAP   = 3'd1;
  localparam logic [ST_W-1:0] ST_LOADI = 3'd2;
  localparam logic [ST_W-1:0] ST_HOLD  = 3'd3;
  localparam logic [ST_W-1:0] ST_CMP   = 3'd4;
  localparam logic [ST_W-1:0] ST_PLACE = 3'd5;
  localparam logic [ST_W-1:0] ST_EMIT  = 3'd6;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic                      last_res;
    logic                      overflow;
  } result_t;

endpackage

@@ hdl/shell_sorter.sv @@
// Shell sort engine: collects a set of signed values, sorts it, emits it.
// Depends on shsort_pkg and shsort_ram.
//
// Usage:
//   Input channel: an item (value, last) transfers at a rising edge where
//   start is high and busy is low. Items without last are only stored, one
//   cycle each, and busy stays low. Beyond MAX_ITEMS stored values further
//   values are dropped and the overflow flag is raised for the whole set.
//   The item marked last (stored too, if room remains) raises busy and
//   starts the sort.
//   Sort: gap starts at n/2 and halves down to 1, one gapped insertion pass
//   per gap, all moves through one store RAM with a registered read port.
//   Each insertion step runs LOADI, HOLD and CMP, with CMP again for every
//   element shifted and PLACE in place of the last CMP when the scan passes
//   zero; each pass adds GAP and a closing LOADI, and a last GAP leads to emit.
//   Result channel: the n sorted values leave on consecutive cycles, each
//   shown for exactly one cycle with result_valid_o high; last_res marks the
//   final one and overflow is the same on every result of the set. The
//   receiver cannot stall. busy drops in the cycle the final result is
//   shown. Reset clears the count, the overflow flag and the sequencer;
//   store contents stay undefined and are never read unwritten.
module shell_sorter
  import shsort_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  item_t   item_i,
  output logic    busy,
  output result_t result_o,
  output logic    result_valid_o
);

  logic [ST_W-1:0]  state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;   // stored set size n
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] gap_q, gap_d;
  logic [CNT_W-1:0] i_q, i_d;           // insertion index, also emit index
  logic signed [J_W-1:0] j_q, j_d;      // scan index, may go negative
  logic [VALUE_W-1:0] hold_q, hold_d;

  // Emit pipeline: flags ride alongside the registered RAM read.
  logic res_valid_q, res_valid_d;
  logic res_last_q, res_last_d;
  logic res_ovf_q, res_ovf_d;

  // RAM port signals
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [VALUE_W-1:0] wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [VALUE_W-1:0] rdata;

  logic               accept;
  logic signed [J_W-1:0] gap_s;
  logic signed [J_W-1:0] j_next;
  logic signed [J_W-1:0] j_plus_gap;
  logic               do_shift;

  assign accept     = start && !busy;
  assign gap_s      = J_W'(signed'({1'b0, gap_q}));
  assign j_next     = j_q - gap_s;
  assign j_plus_gap = j_q + gap_s;
  assign do_shift   = $signed(rdata) > $signed(hold_q);

  shsort_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    gap_d       = gap_q;
    i_d         = i_q;
    j_d         = j_q;
    hold_d      = hold_q;
    res_valid_d = 1'b0;
    res_last_d  = 1'b0;
    res_ovf_d   = res_ovf_q;
    we          = 1'b0;
    waddr       = j_plus_gap[ADDR_W-1:0];
    wdata       = hold_q;
    raddr       = i_q[ADDR_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // Store while room remains, else drop and flag the set.
          if (count_q < CNT_W'(MAX_ITEMS)) begin
            we      = 1'b1;
            waddr   = count_q[ADDR_W-1:0];
            wdata   = item_i.value;
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (item_i.last) begin
            gap_d   = count_d >> 1;
            state_d = ST_GAP;
          end
        end
      end

      ST_GAP: begin
        if (gap_q == '0) begin
          i_d     = '0;
          state_d = ST_EMIT;
        end else begin
          i_d     = gap_q;
          state_d = ST_LOADI;
        end
      end

      ST_LOADI: begin
        // Finish the pass at i == n, else fetch buf[i].
        if (i_q >= count_q) begin
          gap_d   = gap_q >> 1;
          state_d = ST_GAP;
        end else begin
          raddr   = i_q[ADDR_W-1:0];
          state_d = ST_HOLD;
        end
      end

      ST_HOLD: begin
        hold_d  = rdata;
        j_d     = J_W'(signed'({1'b0, i_q})) - gap_s;
        raddr   = j_d[ADDR_W-1:0];
        state_d = ST_CMP;
      end

      ST_CMP: begin
        we = 1'b1;
        if (do_shift) begin
          // Move buf[j] up one gap and keep scanning down.
          wdata = rdata;
          j_d   = j_next;
          raddr = j_next[ADDR_W-1:0];
          if (j_next[J_W-1]) begin
            state_d = ST_PLACE;
          end
        end else begin
          wdata   = hold_q;
          i_d     = i_q + CNT_W'(1);
          state_d = ST_LOADI;
        end
      end

      ST_PLACE: begin
        we      = 1'b1;
        wdata   = hold_q;
        i_d     = i_q + CNT_W'(1);
        state_d = ST_LOADI;
      end

      ST_EMIT: begin
        raddr       = i_q[ADDR_W-1:0];
        res_valid_d = 1'b1;
        res_last_d  = (i_q == count_q - CNT_W'(1));
        res_ovf_d   = ovf_q;
        i_d         = i_q + CNT_W'(1);
        if (res_last_d) begin
          // Empty the store for the next set.
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
      res_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
      res_last_q  <= res_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gap_q     <= gap_d;
    i_q       <= i_d;
    j_q       <= j_d;
    hold_q    <= hold_d;
    res_ovf_q <= res_ovf_d;
  end

  assign busy                = (state_q != ST_IDLE);
  assign result_valid_o      = res_valid_q;
  assign result_o.value_res  = rdata;
  assign result_o.last_res   = res_last_q;
  assign result_o.overflow   = res_ovf_q;

  // A result only follows an emit cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) == ST_EMIT)
    else $error("result shown without an emit cycle");

  // The final result of a set closes the burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_res) |=> !result_valid_o)
    else $error("result follows the final one of a set");

  // The compare step never works on a negative scan index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> !j_q[J_W-1])
    else $error("scan index below zero in compare step");

  // The set size never exceeds the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("element count beyond capacity");

endmodule

@@ hdl/shsort_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instantiated by shell_sorter.
module shsort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/shell_sorter_test.sv @@
// Self-checking testbench for shell_sorter: a directed table, then random sets.
// Sorted results are predicted in-bench and checked one per strobe.
// Depends on shsort_pkg and the shell_sorter RTL.
module shell_sorter_test;
  import shsort_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [VALUE_W-1:0] V_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] V_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam int RANDOM_ITEMS = 410;
  localparam int CYCLE_LIMIT  = 400000;
  // Drain margin once the final result is checked; a stray result in it is flagged.
  localparam int SETTLE_CYCLES = 20;

  // One directed transfer. Where 'typed' is set, the single result of that set is
  // written out here instead of coming from the predictor.
  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 19;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // single-element sets at the extremes and zero, result readable at a glance
    '{'{V_MAX, 1'b1},      1'b1, '{V_MAX, 1'b1, 1'b0}},
    '{'{V_MIN, 1'b1},      1'b1, '{V_MIN, 1'b1, 1'b0}},
    '{'{32'sd0, 1'b1},     1'b1, '{32'sd0, 1'b1, 1'b0}},
    // extremes mixed with values around zero
    '{'{V_MAX, 1'b0},      1'b0, '0},
    '{'{V_MIN, 1'b0},      1'b0, '0},
    '{'{-32'sd1, 1'b0},    1'b0, '0},
    '{'{32'sd1, 1'b0},     1'b0, '0},
    '{'{32'sd0, 1'b1},     1'b0, '0},
    // all values equal
    '{'{32'sd7, 1'b0},     1'b0, '0},
    '{'{32'sd7, 1'b0},     1'b0, '0},
    '{'{32'sd7, 1'b1},     1'b0, '0},
    // strictly descending, exercises gap 3 then gap 1
    '{'{32'sd60, 1'b0},    1'b0, '0},
    '{'{32'sd50, 1'b0},    1'b0, '0},
    '{'{32'sd40, 1'b0},    1'b0, '0},
    '{'{32'sd30, 1'b0},    1'b0, '0},
    '{'{32'sd20, 1'b0},    1'b0, '0},
    '{'{-32'sd10, 1'b1},   1'b0, '0},
    // two elements, one swap
    '{'{32'sd1, 1'b0},     1'b0, '0},
    '{'{-32'sd1, 1'b1},    1'b0, '0}
  };

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  item_t   item_i;
  logic    busy;
  result_t result_o;
  logic    result_valid_o;

  // Travel alongside item_i so the checker knows whether the row is typed.
  logic    row_typed;
  result_t row_res;

  // Predictor state: the set being collected and the sorted results still owed.
  logic signed [VALUE_W-1:0] held [MAX_ITEMS];
  int      held_n = 0;
  logic    held_ovf = 1'b0;
  result_t sorted_q [$];

  int fail_cnt = 0;
  int cycle_cnt = 0;

  shell_sorter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (item_i),
    .busy           (busy),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sort the collected set in place: gap from n/2 halving to 1, gapped insertion.
  task automatic sort_held();
    int gap;
    int i;
    int j;
    logic signed [VALUE_W-1:0] tmp;
    for (gap = held_n / 2; gap > 0; gap = gap / 2) begin
      for (i = gap; i < held_n; i++) begin
        tmp = held[i];
        j = i - gap;
        while (j >= 0 && held[j] > tmp) begin
          held[j + gap] = held[j];
          j -= gap;
        end
        held[j + gap] = tmp;
      end
    end
  endtask

  // Store one accepted value (or drop it when full); on last, queue the sorted set.
  task automatic collect_item(input item_t it);
    result_t r;
    int k;
    if (held_n < int'(MAX_ITEMS)) begin
      held[held_n] = it.value;
      held_n++;
    end else begin
      held_ovf = 1'b1;
    end
    if (it.last) begin
      sort_held();
      for (k = 0; k < held_n; k++) begin
        r.value_res = held[k];
        r.last_res  = (k == held_n - 1);
        r.overflow  = held_ovf;
        sorted_q = {sorted_q, r};
      end
      held_n   = 0;
      held_ovf = 1'b0;
    end
  endtask

  // Check first, then predict: results on this edge always belong to earlier sets,
  // since the first result of a set only comes after the GAP and EMIT states.
  always @(posedge clk_i) begin : check_blk
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (sorted_q.size() == 0) begin
        $error("unexpected result: value_res %0d last_res %0b overflow %0b",
               result_o.value_res, result_o.last_res, result_o.overflow);
        fail_cnt++;
      end else begin
        want = sorted_q.pop_front();
        if (result_o.value_res !== want.value_res) begin
          $error("value_res: expected %0d, got %0d", want.value_res, result_o.value_res);
          fail_cnt++;
        end
        if (result_o.last_res !== want.last_res) begin
          $error("last_res: expected %0b, got %0b", want.last_res, result_o.last_res);
          fail_cnt++;
        end
        if (result_o.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, result_o.overflow);
          fail_cnt++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      collect_item(item_i);
      // Typed rows are single-element sets: swap in the written-out result.
      if (row_typed && item_i.last) sorted_q[sorted_q.size() - 1] = row_res;
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[shell_sorter] ERROR");
      $finish;
    end
  end

  // Drive one transfer: idle a random number of cycles, present the item at the
  // falling edge, and hold it until a rising edge with busy low takes it.
  // Leave start high afterward so back-to-back items need no second assignment.
  task automatic send_item(input item_t it, input int max_gap,
                           input logic typed, input result_t res);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start     <= 1'b1;
    item_i    <= it;
    row_typed <= typed;
    row_res   <= res;
    do @(posedge clk_i); while (busy);
  endtask

  // Values: full range, a narrow band around zero (many duplicates), or extremes.
  function automatic logic signed [VALUE_W-1:0] pick_value(input int mode);
    logic signed [VALUE_W-1:0] v;
    case (mode)
      0: v = $urandom;
      1: v = int'($urandom_range(0, 15)) - 8;
      default: begin
        case ($urandom_range(0, 4))
          0: v = V_MAX;
          1: v = V_MIN;
          2: v = '0;
          3: v = -1;
          default: v = 1;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin : stim_blk
    int sent;
    int set_idx;
    int set_len;
    int mode;
    int max_gap;
    int k;
    item_t it;
    rst_ni    = 1'b0;
    start     = 1'b0;
    item_i    = '0;
    row_typed = 1'b0;
    row_res   = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: walk the table.
    for (k = 0; k < DIR_ROWS; k++) begin
      send_item(DIR_TABLE[k].it, 9, DIR_TABLE[k].typed, DIR_TABLE[k].res);
    end

    // Random part: whole sets with random content, sized mostly small, with
    // a few full and overflowing sets forced early so they always occur.
    sent    = 0;
    set_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      // Hold off until every owed result has come, at least once, then now and then.
      // Drop start first so the last transfer is not taken again.
      if (set_idx == 0 || $urandom_range(0, 4) == 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        while (sorted_q.size() != 0) @(negedge clk_i);
      end
      if (set_idx == 1 || set_idx == 4) begin
        set_len = MAX_ITEMS + $urandom_range(1, 6);
      end else if (set_idx == 2) begin
        set_len = MAX_ITEMS;
      end else begin
        case ($urandom_range(0, 19))
          0: set_len = $urandom_range(17, MAX_ITEMS);
          1: set_len = MAX_ITEMS + $urandom_range(1, 4);
          default: set_len = $urandom_range(1, 16);
        endcase
      end
      mode    = $urandom_range(0, 3);
      // Some sets run back to back with no idle cycles at all.
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 9;
      for (k = 0; k < set_len; k++) begin
        it.value = pick_value(mode == 3 ? int'($urandom_range(0, 2)) : mode);
        it.last  = (k == set_len - 1);
        send_item(it, max_gap, 1'b0, '0);
        sent++;
      end
      set_idx++;
    end

    @(negedge clk_i);
    start <= 1'b0;

    // Drain: wait for every owed result, then a short settle window.
    while (sorted_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("[shell_sorter] OK");
    end else begin
      $display("[shell_sorter] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/shsort_pkg.sv
hdl/shsort_ram.sv
hdl/shell_sorter.sv
tb/shell_sorter_test.sv
